/* design/assert_macros.svh */
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/acsd_pkg.sv */
// Shared types, codes and attribute update function of the CSI sequence decoder.
package acsd_pkg;

  localparam int PARAM_BITS_DEF = 16;

  localparam logic [2:0] KIND_PRINT   = 3'd0;
  localparam logic [2:0] KIND_MOVE    = 3'd1;
  localparam logic [2:0] KIND_ERASE   = 3'd2;
  localparam logic [2:0] KIND_SAVE    = 3'd3;
  localparam logic [2:0] KIND_RESTORE = 3'd4;
  localparam logic [2:0] KIND_ATTR    = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN = 3'd6;
  localparam logic [2:0] KIND_ERROR   = 3'd7;

  localparam logic [1:0] POS_KEEP = 2'd0;
  localparam logic [1:0] POS_ADD  = 2'd1;
  localparam logic [1:0] POS_SET  = 2'd2;

  localparam logic [2:0] REGION_LINE_BASE = 3'd4;

  localparam logic [3:0] COLOR_DEFAULT = 4'd8;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUEST  = 8'h3F;

  typedef struct packed {
    logic [3:0] fg;
    logic [3:0] bg;
    logic [7:0] mode;
  } attr_t;

  localparam attr_t ATTR_DEFAULT = '{fg: COLOR_DEFAULT, bg: COLOR_DEFAULT, mode: 8'h00};

  function automatic logic [7:0] flag_of(input logic [3:0] idx);
    logic [7:0] f;
    case (idx)
      4'd1: f = 8'h01;
      4'd2: f = 8'h02;
      4'd3: f = 8'h04;
      4'd4: f = 8'h08;
      4'd5: f = 8'h10;
      4'd7: f = 8'h20;
      4'd8: f = 8'h40;
      4'd9: f = 8'h80;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

  // Applies one SGR code; big marks a code above 127, which is always ignored.
  function automatic attr_t sgr_apply(input attr_t a, input logic [6:0] c, input logic big);
    attr_t r;
    logic [6:0] d;
    r = a;
    d = '0;
    if (!big) begin
      if (c == 7'd0) begin
        r = ATTR_DEFAULT;
      end else if (c >= 7'd30 && c <= 7'd37) begin
        d = c - 7'd30;
        r.fg = d[3:0];
      end else if (c >= 7'd90 && c <= 7'd97) begin
        d = c - 7'd90;
        r.fg = d[3:0];
      end else if (c >= 7'd40 && c <= 7'd47) begin
        d = c - 7'd40;
        r.bg = d[3:0];
      end else if (c >= 7'd100 && c <= 7'd107) begin
        d = c - 7'd100;
        r.bg = d[3:0];
      end else if (c >= 7'd1 && c <= 7'd9) begin
        r.mode = a.mode | flag_of(c[3:0]);
      end else if (c >= 7'd21 && c <= 7'd29) begin
        d = c - 7'd20;
        r.mode = a.mode & ~flag_of(d[3:0]);
      end
    end
    return r;
  endfunction

endpackage

/* design/ansi_csi_sequence_decoder_unit.sv */
// Top level of the CSI sequence decoder: byte stream in, decoded results out.
// A byte that yields a result shows it on the output in the cycle after its transfer.
// Throughput: one byte per cycle; input stalls only while a held result is stalled.
// Every byte is decoded in a single pass from the sequence state into the result register.
// Reset (synchronous, active low) returns to ground text with default attributes.
`include "assert_macros.svh"

module ansi_csi_sequence_decoder_unit #(
  parameter int PARAM_BITS = acsd_pkg::PARAM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_char_out,
  output logic [1:0]         out_row_mode,
  output logic signed [16:0] out_row_value,
  output logic [1:0]         out_col_mode,
  output logic signed [16:0] out_col_value,
  output logic [2:0]         out_erase_region,
  output logic [3:0]         out_fg_index,
  output logic [3:0]         out_bg_index,
  output logic [7:0]         out_mode_flags
);
  import acsd_pkg::*;

  localparam int WIDE = 33;
  localparam int EXT  = PARAM_BITS + 4;

  localparam logic [1:0] PH_GROUND = 2'd0;
  localparam logic [1:0] PH_ESC    = 2'd1;
  localparam logic [1:0] PH_CSI    = 2'd2;
  localparam logic [1:0] PH_OSC    = 2'd3;

  logic [1:0]            phase_r, phase_nxt;
  logic                  priv_r, priv_nxt;
  logic [PARAM_BITS-1:0] acc_r, acc_nxt;
  logic [PARAM_BITS-1:0] first_r, first_nxt;
  logic [PARAM_BITS-1:0] second_r, second_nxt;
  logic [1:0]            pcnt_r, pcnt_nxt;
  attr_t                 shadow_r, shadow_nxt;
  attr_t                 cur_r, cur_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [7:0]  char_r, char_nxt;
  logic [1:0]  rmode_r, rmode_nxt;
  logic [16:0] rval_r, rval_nxt;
  logic [1:0]  cmode_r, cmode_nxt;
  logic [16:0] cval_r, cval_nxt;
  logic [2:0]  region_r, region_nxt;
  attr_t       attr_r;

  logic              in_fire;
  logic              got;
  logic              is_digit;
  logic [3:0]        dsub;
  logic [EXT-1:0]    acc_mul;
  logic [PARAM_BITS-1:0] acc_inc;
  logic [WIDE-1:0]   acc_w;
  logic [WIDE-1:0]   first_w;
  logic [WIDE-1:0]   second_w;
  logic [WIDE-1:0]   n_w;
  logic [PARAM_BITS-1:0] first_v;
  logic [PARAM_BITS-1:0] second_v;
  logic [15:0]       n_cl;
  logic [15:0]       first_cl;
  logic [15:0]       second_cl;
  logic [16:0]       n_pos;
  logic [16:0]       n_neg;
  logic              sgr_big;
  attr_t             sgr_res;
  logic              priv_ok;
  logic              text_fire;
  logic              print_out;
  logic              other_out;
  logic              pos_clear;
  logic              ranges_ok;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  assign dsub     = 4'(in_byte_in - CH_ZERO);
  assign is_digit = (in_byte_in >= CH_ZERO) && (in_byte_in <= CH_NINE);
  assign acc_mul  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                  + {{(EXT-4){1'b0}}, dsub};
  assign acc_inc  = (acc_mul[EXT-1:PARAM_BITS] != '0) ? {PARAM_BITS{1'b1}}
                                                      : acc_mul[PARAM_BITS-1:0];

  assign first_v  = (pcnt_r == 2'd0) ? acc_r : first_r;
  assign second_v = (pcnt_r == 2'd1) ? acc_r : second_r;
  assign acc_w    = {{(WIDE-PARAM_BITS){1'b0}}, acc_r};
  assign first_w  = {{(WIDE-PARAM_BITS){1'b0}}, first_v};
  assign second_w = {{(WIDE-PARAM_BITS){1'b0}}, second_v};
  assign n_w      = (first_w != '0) ? first_w : {{(WIDE-1){1'b0}}, 1'b1};

  assign n_cl      = (n_w > WIDE'(65535)) ? 16'hFFFF : n_w[15:0];
  assign first_cl  = (first_w > WIDE'(65535)) ? 16'hFFFF : first_w[15:0];
  assign second_cl = (second_w > WIDE'(65535)) ? 16'hFFFF : second_w[15:0];
  assign n_pos     = {1'b0, n_cl};
  assign n_neg     = 17'd0 - {1'b0, n_cl};

  assign sgr_big = acc_w > WIDE'(127);
  assign sgr_res = sgr_apply(shadow_r, acc_w[6:0], sgr_big);

  assign priv_ok = ((in_byte_in == "h") || (in_byte_in == "l")) && (pcnt_r == 2'd0)
                && ((acc_w == WIDE'(25)) || (acc_w == WIDE'(47))
                 || (acc_w == WIDE'(1049)) || (acc_w == WIDE'(2004)));

  always_comb begin
    phase_nxt  = phase_r;
    priv_nxt   = priv_r;
    acc_nxt    = acc_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    pcnt_nxt   = pcnt_r;
    shadow_nxt = shadow_r;
    cur_nxt    = cur_r;
    got        = 1'b0;
    kind_nxt   = KIND_PRINT;
    char_nxt   = 8'h00;
    rmode_nxt  = POS_KEEP;
    rval_nxt   = 17'd0;
    cmode_nxt  = POS_KEEP;
    cval_nxt   = 17'd0;
    region_nxt = 3'd0;
    if (in_fire) begin
      case (phase_r)
        PH_GROUND: begin
          if (in_byte_in == CH_ESC) begin
            phase_nxt = PH_ESC;
          end else begin
            got      = 1'b1;
            char_nxt = in_byte_in;
          end
        end
        PH_ESC: begin
          if (in_byte_in == CH_LBRACK) begin
            phase_nxt  = PH_CSI;
            priv_nxt   = 1'b0;
            acc_nxt    = '0;
            first_nxt  = '0;
            second_nxt = '0;
            pcnt_nxt   = 2'd0;
            shadow_nxt = cur_r;
          end else if (in_byte_in == CH_RBRACK) begin
            phase_nxt = PH_OSC;
          end else begin
            phase_nxt = PH_GROUND;
            got       = 1'b1;
            kind_nxt  = KIND_ERROR;
          end
        end
        PH_OSC: begin
          phase_nxt = PH_GROUND;
          if (in_byte_in != CH_ZERO) begin
            got      = 1'b1;
            kind_nxt = KIND_ERROR;
          end
        end
        PH_CSI: begin
          if (is_digit) begin
            if (priv_r && (in_byte_in == CH_ZERO) && (acc_r == '0)) begin
              pcnt_nxt = 2'd3;
            end
            acc_nxt = acc_inc;
          end else if (!priv_r && (in_byte_in == CH_SEMI)) begin
            if (pcnt_r == 2'd0) begin
              first_nxt = acc_r;
            end else if (pcnt_r == 2'd1) begin
              second_nxt = acc_r;
            end
            shadow_nxt = sgr_res;
            acc_nxt    = '0;
            if (pcnt_r != 2'd3) begin
              pcnt_nxt = pcnt_r + 2'd1;
            end
          end else if (!priv_r && (in_byte_in == CH_QUEST)) begin
            priv_nxt = 1'b1;
            acc_nxt  = '0;
            pcnt_nxt = 2'd0;
          end else begin
            phase_nxt = PH_GROUND;
            if (priv_r) begin
              if (!priv_ok) begin
                got      = 1'b1;
                kind_nxt = KIND_UNKNOWN;
              end
            end else begin
              got      = 1'b1;
              kind_nxt = KIND_UNKNOWN;
              case (in_byte_in)
                "m": begin
                  shadow_nxt = sgr_res;
                  cur_nxt    = sgr_res;
                  kind_nxt   = KIND_ATTR;
                end
                "A", "M": begin
                  kind_nxt  = KIND_MOVE;
                  rmode_nxt = POS_ADD;
                  rval_nxt  = n_neg;
                end
                "B": begin
                  kind_nxt  = KIND_MOVE;
                  rmode_nxt = POS_ADD;
                  rval_nxt  = n_pos;
                end
                "C": begin
                  kind_nxt  = KIND_MOVE;
                  cmode_nxt = POS_ADD;
                  cval_nxt  = n_pos;
                end
                "D": begin
                  kind_nxt  = KIND_MOVE;
                  cmode_nxt = POS_ADD;
                  cval_nxt  = n_neg;
                end
                "E": begin
                  kind_nxt  = KIND_MOVE;
                  rmode_nxt = POS_ADD;
                  rval_nxt  = n_pos;
                  cmode_nxt = POS_SET;
                end
                "F": begin
                  kind_nxt  = KIND_MOVE;
                  rmode_nxt = POS_ADD;
                  rval_nxt  = n_neg;
                  cmode_nxt = POS_SET;
                end
                "G": begin
                  kind_nxt  = KIND_MOVE;
                  cmode_nxt = POS_SET;
                  cval_nxt  = n_pos;
                end
                "H", "f": begin
                  if (pcnt_r == 2'd1) begin
                    kind_nxt  = KIND_MOVE;
                    rmode_nxt = POS_SET;
                    rval_nxt  = {1'b0, first_cl};
                    cmode_nxt = POS_SET;
                    cval_nxt  = {1'b0, second_cl};
                  end else if (first_w == '0) begin
                    kind_nxt  = KIND_MOVE;
                    rmode_nxt = POS_SET;
                    cmode_nxt = POS_SET;
                  end
                end
                "s": begin
                  kind_nxt = KIND_SAVE;
                end
                "u": begin
                  kind_nxt = KIND_RESTORE;
                end
                "J": begin
                  if (first_w <= WIDE'(3)) begin
                    kind_nxt   = KIND_ERASE;
                    region_nxt = first_w[2:0];
                  end
                end
                "K": begin
                  if (first_w <= WIDE'(2)) begin
                    kind_nxt   = KIND_ERASE;
                    region_nxt = REGION_LINE_BASE + first_w[2:0];
                  end
                end
                default: begin
                  kind_nxt = KIND_UNKNOWN;
                end
              endcase
            end
          end
        end
        default: begin
          phase_nxt = PH_GROUND;
        end
      endcase
    end
  end

  assign out_valid_nxt = (in_fire & got) | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_GROUND;
      priv_r      <= 1'b0;
      acc_r       <= '0;
      first_r     <= '0;
      second_r    <= '0;
      pcnt_r      <= 2'd0;
      shadow_r    <= ATTR_DEFAULT;
      cur_r       <= ATTR_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      priv_r      <= priv_nxt;
      acc_r       <= acc_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      pcnt_r      <= pcnt_nxt;
      shadow_r    <= shadow_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && got) begin
      kind_r   <= kind_nxt;
      char_r   <= char_nxt;
      rmode_r  <= rmode_nxt;
      rval_r   <= rval_nxt;
      cmode_r  <= cmode_nxt;
      cval_r   <= cval_nxt;
      region_r <= region_nxt;
      attr_r   <= cur_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_char_out     = char_r;
  assign out_row_mode     = rmode_r;
  assign out_row_value    = $signed(rval_r);
  assign out_col_mode     = cmode_r;
  assign out_col_value    = $signed(cval_r);
  assign out_erase_region = region_r;
  assign out_fg_index     = attr_r.fg;
  assign out_bg_index     = attr_r.bg;
  assign out_mode_flags   = attr_r.mode;

  assign text_fire = in_fire && (phase_r == PH_GROUND) && (in_byte_in != CH_ESC);
  assign print_out = out_valid_r && (kind_r == KIND_PRINT);
  assign other_out = out_valid_r && (kind_r != KIND_MOVE);
  assign pos_clear = (rmode_r == POS_KEEP) && (cmode_r == POS_KEEP)
                  && (rval_r == 17'd0) && (cval_r == 17'd0);
  assign ranges_ok = (attr_r.fg <= COLOR_DEFAULT) && (attr_r.bg <= COLOR_DEFAULT)
                  && (region_r != 3'd7);

  `ASSERT_IMP(a_stall_only_when_full, clk, rst_n, in_stall, out_valid_r, "stall while empty")
  `ASSERT_NXT(a_text_print, clk, rst_n, text_fire, print_out && char_r == $past(in_byte_in), "no print")
  `ASSERT_IMP(a_move_fields, clk, rst_n, other_out, pos_clear, "position set on a non-move result")
  `ASSERT_IMP(a_color_range, clk, rst_n, out_valid_r, ranges_ok, "field out of range")

endmodule
